@@ design/block_cache_directory_lru_assert.svh @@
// Assertion macros for the block cache directory checker.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef BLOCK_CACHE_DIRECTORY_LRU_ASSERT_SVH
`define BLOCK_CACHE_DIRECTORY_LRU_ASSERT_SVH

// Same-cycle property.
`define BCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define BCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bcd_pkg.sv @@
package bcd_pkg;

  localparam int unsigned SlotCount  = 16;
  localparam int unsigned BlockBytes = 512;
  localparam int unsigned LenW       = 10;
  localparam int unsigned SlotNumW   = 4;

  // block size one bit wider than a length, for clipping math
  localparam logic [LenW:0] BlockLimit = (LenW + 1)'(BlockBytes);

  typedef enum logic [1:0] {
    KIND_LOOKUP    = 2'd0,
    KIND_FILL      = 2'd1,
    KIND_INVAL_ONE = 2'd2,
    KIND_INVAL_ALL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_HIT          = 3'd0,
    STAT_MISS         = 3'd1,
    STAT_EOF          = 3'd2,
    STAT_FILLED       = 3'd3,
    STAT_BACKEND_MISS = 3'd4,
    STAT_INVALIDATED  = 3'd5,
    STAT_BYPASS       = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [31:0]       file_tag;
    logic [22:0]       block_index;
    logic [8:0]        offset_in_block;
    logic [LenW-1:0]   request_length;
    logic [LenW-1:0]   loaded_size;
  } bcd_in_t;

  typedef struct packed {
    status_e           status;
    logic [SlotNumW-1:0] slot_number;
    logic [LenW-1:0]   served_length;
    logic [31:0]       hit_count;
    logic [31:0]       miss_count;
    logic [31:0]       fill_count;
    logic [31:0]       invalidation_count;
  } bcd_out_t;

  typedef struct packed {
    logic [31:0]     file_tag;
    logic [22:0]     block_index;
    logic [LenW-1:0] valid_bytes;
    logic [31:0]     age;
  } slot_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic vld_wr;
    logic vld_val;
  } mem_ctl_t;

  typedef struct packed {
    logic clr;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic            hit;
    logic            free_found;
    logic [LenW-1:0] hit_vb;
  } scan_res_t;

endpackage

@@ design/bcd_slot_mem.sv @@
module bcd_slot_mem import bcd_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount,
  localparam int unsigned IdxW = $clog2(SLOT_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mem_ctl_t              ctl_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  slot_entry_t           wr_entry_i,
  output slot_entry_t           rd_entry_o,
  output logic [SLOT_COUNT-1:0] vld_o
);

  slot_entry_t           mem_q [SLOT_COUNT];
  slot_entry_t           rd_q;
  logic [SLOT_COUNT-1:0] vld_q;

  // entry store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.vld_wr) begin
      vld_q[wr_addr_i] <= ctl_i.vld_val;
    end
  end

  assign rd_entry_o = rd_q;
  assign vld_o      = vld_q;

endmodule

@@ design/bcd_scan.sv @@
module bcd_scan import bcd_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount,
  localparam int unsigned IdxW = $clog2(SLOT_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_ctl_t       ctl_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic            vld_i,
  input  slot_entry_t     entry_i,
  input  logic [31:0]     tag_i,
  input  logic [22:0]     blk_i,
  output logic            tag_eq_o,
  output scan_res_t       res_o,
  output logic [IdxW-1:0] hit_idx_o,
  output logic [IdxW-1:0] free_idx_o,
  output logic [IdxW-1:0] old_idx_o
);

  logic            hit_q, free_q, old_seen_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, old_idx_q;
  logic [LenW-1:0] hit_vb_q;
  logic [31:0]     old_age_q;
  logic            tag_eq, match, age_lt, take_hit, take_free, take_old;

  // one shared compare unit, one slot per step
  assign tag_eq    = (entry_i.file_tag == tag_i);
  assign match     = vld_i && tag_eq && (entry_i.block_index == blk_i);
  assign age_lt    = (entry_i.age < old_age_q);
  assign take_hit  = ctl_i.step && match && !hit_q;
  assign take_free = ctl_i.step && !vld_i && !free_q;
  // strict less-than keeps the lowest slot on ties
  assign take_old  = ctl_i.step && vld_i && (!old_seen_q || age_lt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      old_seen_q <= 1'b0;
    end else if (ctl_i.clr) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      old_seen_q <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_q <= 1'b1;
      end
      if (take_free) begin
        free_q <= 1'b1;
      end
      if (take_old) begin
        old_seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q <= idx_i;
      hit_vb_q  <= entry_i.valid_bytes;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
    if (take_old) begin
      old_idx_q <= idx_i;
      old_age_q <= entry_i.age;
    end
  end

  assign tag_eq_o         = tag_eq;
  assign res_o.hit        = hit_q;
  assign res_o.free_found = free_q;
  assign res_o.hit_vb     = hit_vb_q;
  assign hit_idx_o        = hit_idx_q;
  assign free_idx_o       = free_idx_q;
  assign old_idx_o        = old_idx_q;

endmodule

@@ design/block_cache_directory_lru.sv @@
// Sequence: a lookup, fill or invalidation scans every slot, then resolves, then loads its result word
// into the output register; bypassed words skip the scan and resolve steps.
// Occupancy: the block takes no new word until the last one's result word is loaded; the
// scan reads one slot per cycle through the entry memory's single read port.
// Reset (async, active low): all slots invalid at once, counters zero, age clock one,
// cache enabled. No clearing pass is needed.
module block_cache_directory_lru import bcd_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCount
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bcd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bcd_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  state_e state_q, state_d;

  // scan counter: issues read k, processes slot k-1 (read data is registered)
  logic [CntW-1:0] cnt_q;
  bcd_in_t         req_q;
  logic            en_q;
  logic [31:0]     age_clk_q;
  logic [31:0]     hits_q, misses_q, fills_q, invals_q;

  status_e             res_status_q;
  logic [SlotNumW-1:0] res_slot_q;
  logic [LenW-1:0]     res_served_q;

  logic     out_valid_q;
  bcd_out_t out_q;

  // memory and scan unit hookup
  mem_ctl_t              mem_ctl;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  slot_entry_t           wr_entry, rd_entry;
  logic [SLOT_COUNT-1:0] vld;
  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;
  logic                  tag_eq;
  logic [IdxW-1:0]       hit_idx, free_idx, old_idx;

  logic            accept, bypass_in, scan_done, step, is_inval, kill, out_free, load_out;
  logic [IdxW-1:0] proc_idx;

  // resolve-step decisions
  status_e             rs_status;
  logic [SlotNumW-1:0] rs_slot;
  logic [LenW-1:0]     rs_served;
  logic                rs_hit, rs_miss, rs_fill, rs_bump;
  logic                rs_wr_en, rs_vld_wr, rs_vld_val;
  logic [IdxW-1:0]     rs_addr, victim;
  logic [31:0]         stamp;
  logic                eof;
  logic [LenW:0]       room_blk, room_vb, want;
  logic [LenW-1:0]     loaded_sat;

  bcd_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry),
    .vld_o      (vld)
  );

  bcd_scan #(.SLOT_COUNT(SLOT_COUNT)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (proc_idx),
    .vld_i      (vld[proc_idx]),
    .entry_i    (rd_entry),
    .tag_i      (req_q.file_tag),
    .blk_i      (req_q.block_index),
    .tag_eq_o   (tag_eq),
    .res_o      (scan_res),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .old_idx_o  (old_idx)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_DONE) && out_free;

  // lookup or fill on a disabled cache, or empty lookup: nothing to scan, nothing changes
  assign bypass_in = (((in_data_i.kind == KIND_LOOKUP) || (in_data_i.kind == KIND_FILL))
                      && !en_q)
                     || ((in_data_i.kind == KIND_LOOKUP) && (in_data_i.request_length == '0));

  assign scan_done = (cnt_q == CntW'(SLOT_COUNT));
  assign proc_idx  = IdxW'(cnt_q - CntW'(1));
  assign step      = (state_q == ST_SCAN) && (cnt_q != '0);
  assign is_inval  = (req_q.kind == KIND_INVAL_ONE) || (req_q.kind == KIND_INVAL_ALL);
  assign kill      = step && is_inval && vld[proc_idx]
                     && ((req_q.kind == KIND_INVAL_ALL) || tag_eq);

  // ---------------------------------------------------------------------------
  // Resolve: acts on what the scan found
  // ---------------------------------------------------------------------------
  assign stamp = age_clk_q + 32'd1;

  always_comb begin
    // matching slot first, then first free slot, then the oldest
    if (scan_res.hit) begin
      victim = hit_idx;
    end else if (scan_res.free_found) begin
      victim = free_idx;
    end else begin
      victim = old_idx;
    end

    eof      = ({1'b0, req_q.offset_in_block} >= scan_res.hit_vb);
    room_blk = BlockLimit - {2'b00, req_q.offset_in_block};
    room_vb  = {1'b0, scan_res.hit_vb} - {2'b00, req_q.offset_in_block};
    want     = {1'b0, req_q.request_length};
    if (want > room_blk) begin
      want = room_blk;
    end
    if (want > room_vb) begin
      want = room_vb;
    end

    if ({1'b0, req_q.loaded_size} > BlockLimit) begin
      loaded_sat = LenW'(BlockLimit);
    end else begin
      loaded_sat = req_q.loaded_size;
    end

    rs_status  = STAT_INVALIDATED;
    rs_slot    = '0;
    rs_served  = '0;
    rs_hit     = 1'b0;
    rs_miss    = 1'b0;
    rs_fill    = 1'b0;
    rs_bump    = 1'b0;
    rs_wr_en   = 1'b0;
    rs_vld_wr  = 1'b0;
    rs_vld_val = 1'b0;
    rs_addr    = victim;

    unique case (req_q.kind)
      KIND_LOOKUP: begin
        if (!scan_res.hit) begin
          rs_status = STAT_MISS;
          rs_miss   = 1'b1;
        end else begin
          rs_slot = SlotNumW'(hit_idx);
          rs_addr = hit_idx;
          if (eof) begin
            rs_status = STAT_EOF;
          end else begin
            rs_status = STAT_HIT;
            rs_served = LenW'(want);
            rs_hit    = 1'b1;
            rs_bump   = 1'b1;
            rs_wr_en  = 1'b1;   // age refresh
          end
        end
      end
      KIND_FILL: begin
        // victim is cleared; reinstalled only if the backend gave bytes
        rs_slot   = SlotNumW'(victim);
        rs_vld_wr = 1'b1;
        if (req_q.loaded_size == '0) begin
          rs_status = STAT_BACKEND_MISS;
        end else begin
          rs_status  = STAT_FILLED;
          rs_vld_val = 1'b1;
          rs_wr_en   = 1'b1;
          rs_bump    = 1'b1;
          rs_fill    = 1'b1;
        end
      end
      KIND_INVAL_ONE, KIND_INVAL_ALL: begin
        rs_status = STAT_INVALIDATED;
      end
      default: begin
        rs_status = STAT_INVALIDATED;
      end
    endcase
  end

  assign wr_entry.file_tag    = req_q.file_tag;
  assign wr_entry.block_index = req_q.block_index;
  assign wr_entry.valid_bytes = (req_q.kind == KIND_FILL) ? loaded_sat : scan_res.hit_vb;
  assign wr_entry.age         = stamp;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = bypass_in ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    scan_ctl.clr     = accept;
    scan_ctl.step    = step;
    mem_ctl.rd_en    = 1'b0;
    mem_ctl.wr_en    = 1'b0;
    mem_ctl.vld_wr   = 1'b0;
    mem_ctl.vld_val  = 1'b0;
    rd_addr          = cnt_q[IdxW-1:0];
    wr_addr          = rs_addr;
    unique case (state_q)
      ST_SCAN: begin
        mem_ctl.rd_en  = !scan_done;
        mem_ctl.vld_wr = kill;        // invalidation drops valid as it goes
        wr_addr        = proc_idx;
      end
      ST_RESOLVE: begin
        mem_ctl.wr_en   = rs_wr_en;
        mem_ctl.vld_wr  = rs_vld_wr;
        mem_ctl.vld_val = rs_vld_val;
      end
      ST_IDLE, ST_DONE: begin
        mem_ctl.rd_en = 1'b0;
      end
      default: begin
        mem_ctl.rd_en = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers and counters
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      en_q        <= 1'b1;
      age_clk_q   <= 32'd1;
      hits_q      <= '0;
      misses_q    <= '0;
      fills_q     <= '0;
      invals_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= CntW'(cnt_q + CntW'(1));
      end
      if (kill) begin
        invals_q <= invals_q + 32'd1;
      end
      if (state_q == ST_RESOLVE) begin
        if (rs_hit) begin
          hits_q <= hits_q + 32'd1;
        end
        if (rs_miss) begin
          misses_q <= misses_q + 32'd1;
        end
        if (rs_fill) begin
          fills_q <= fills_q + 32'd1;
        end
        if (rs_bump) begin
          age_clk_q <= stamp;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q        <= in_data_i;
      res_status_q <= STAT_BYPASS;
      res_slot_q   <= '0;
      res_served_q <= '0;
    end else if (state_q == ST_RESOLVE) begin
      res_status_q <= rs_status;
      res_slot_q   <= rs_slot;
      res_served_q <= rs_served;
    end
    if (load_out) begin
      out_q.status             <= res_status_q;
      out_q.slot_number        <= res_slot_q;
      out_q.served_length      <= res_served_q;
      out_q.hit_count          <= hits_q;
      out_q.miss_count         <= misses_q;
      out_q.fill_count         <= fills_q;
      out_q.invalidation_count <= invals_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/bcd_checker.sv @@
`include "block_cache_directory_lru_assert.svh"

module bcd_checker import bcd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input bcd_out_t out_data_o
);

  `BCD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word dropped or changed while stalled")

  `BCD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "block took a second word while busy")

  `BCD_ASSERT(a_hit_len, out_valid_o && (out_data_o.status == STAT_HIT) |-> out_data_o.served_length != '0, "hit served no bytes")

  `BCD_ASSERT(a_other_len, out_valid_o && (out_data_o.status != STAT_HIT) |-> out_data_o.served_length == '0, "bytes served without a hit")

  `BCD_ASSERT(a_no_slot, out_valid_o && ((out_data_o.status == STAT_MISS) || (out_data_o.status == STAT_BYPASS) || (out_data_o.status == STAT_INVALIDATED)) |-> out_data_o.slot_number == '0, "slot reported without a slot")

endmodule

bind block_cache_directory_lru bcd_checker u_bcd_checker (.*);

@@ verif/tb_block_cache_directory_lru.sv @@
`timescale 1ns / 1ps

module tb_block_cache_directory_lru;
  import bcd_pkg::*;

  // Idle tail after the last reply.
  localparam int unsigned DrainCycles = 30;
  // Long receiver hold-off, enough to back the block up into its input.
  localparam int unsigned LongStall   = 400;
  localparam int unsigned MaxReports  = 10;

  localparam logic [31:0] TagLow  = 32'h0000_0000;
  localparam logic [31:0] TagHigh = 32'hFFFF_FFFF;
  localparam logic [22:0] BlkHigh = 23'h7F_FFFF;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_ready_o;
  bcd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  bcd_out_t out_data_o;

  block_cache_directory_lru DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------
  // Directory shadow: slot contents, age clock, counters, enable bit.
  // ---------------------------------------------------------------------
  logic            dir_enable;
  logic            dir_valid [SlotCount];
  logic [31:0]     dir_tag   [SlotCount];
  logic [22:0]     dir_blk   [SlotCount];
  logic [LenW-1:0] dir_bytes [SlotCount];
  logic [31:0]     dir_age   [SlotCount];
  logic [31:0]     dir_age_clk;
  logic [31:0]     dir_hits;
  logic [31:0]     dir_misses;
  logic [31:0]     dir_fills;
  logic [31:0]     dir_invals;

  // Predicted reply words, oldest first.
  bcd_out_t reply_q[$];

  int unsigned mismatch_count;
  bit          no_idle;          // both sides run gap-free while set
  int unsigned long_stall_req;   // picked up once by the reply sink

  // Key pools: few tags x few blocks, more keys than slots so LRU eviction
  // happens and lookups after fills hit often.
  logic [31:0] tag_pool [4];
  logic [22:0] blk_pool [6];

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic reset_directory();
    dir_enable  = 1'b1;
    for (int i = 0; i < SlotCount; i++) begin
      dir_valid[i] = 1'b0;
      dir_tag[i]   = '0;
      dir_blk[i]   = '0;
      dir_bytes[i] = '0;
      dir_age[i]   = '0;
    end
    dir_age_clk = 32'd1;
    dir_hits    = '0;
    dir_misses  = '0;
    dir_fills   = '0;
    dir_invals  = '0;
  endtask

  function automatic int find_slot(logic [31:0] tag, logic [22:0] blk);
    int s;
    s = -1;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (dir_valid[i] && dir_tag[i] == tag && dir_blk[i] == blk) s = i;
    end
    return s;
  endfunction

  // Applies one input word to the shadow and returns the reply it causes.
  function automatic bcd_out_t directory_update(bcd_in_t w);
    bcd_out_t    r;
    int          s;
    bit          found;
    int unsigned want;
    logic [LenW-1:0] fill_len;
    r        = '0;
    r.status = STAT_BYPASS;
    case (w.kind)
      KIND_LOOKUP: begin
        if (dir_enable && w.request_length != '0) begin
          s = find_slot(w.file_tag, w.block_index);
          if (s < 0) begin
            dir_misses = dir_misses + 32'd1;
            r.status   = STAT_MISS;
          end else begin
            r.slot_number = s[SlotNumW-1:0];
            if (w.offset_in_block >= dir_bytes[s]) begin
              r.status = STAT_EOF;   // offset at or past valid bytes
            end else begin
              want = w.request_length;
              if (want > BlockBytes - w.offset_in_block) want = BlockBytes - w.offset_in_block;
              if (want > dir_bytes[s] - w.offset_in_block) want = dir_bytes[s] - w.offset_in_block;
              r.served_length = want[LenW-1:0];
              dir_age_clk     = dir_age_clk + 32'd1;
              dir_age[s]      = dir_age_clk;
              dir_hits        = dir_hits + 32'd1;
              r.status        = STAT_HIT;
            end
          end
        end
      end
      KIND_FILL: begin
        if (dir_enable) begin
          s = find_slot(w.file_tag, w.block_index);
          if (s < 0) begin
            // first invalid slot, else lowest-numbered oldest
            s     = 0;
            found = 1'b0;
            for (int i = 0; i < SlotCount; i++) begin
              if (!found) begin
                if (!dir_valid[i]) begin
                  s     = i;
                  found = 1'b1;
                end else if (dir_age[i] < dir_age[s]) begin
                  s = i;
                end
              end
            end
          end
          r.slot_number = s[SlotNumW-1:0];
          dir_valid[s]  = 1'b0;
          dir_tag[s]    = '0;
          dir_blk[s]    = '0;
          dir_bytes[s]  = '0;
          dir_age[s]    = '0;
          if (w.loaded_size == '0) begin
            r.status = STAT_BACKEND_MISS;
          end else begin
            fill_len = (w.loaded_size > BlockBytes) ? LenW'(BlockBytes) : w.loaded_size;
            dir_valid[s] = 1'b1;
            dir_tag[s]   = w.file_tag;
            dir_blk[s]   = w.block_index;
            dir_bytes[s] = fill_len;
            dir_age_clk  = dir_age_clk + 32'd1;
            dir_age[s]   = dir_age_clk;
            dir_fills    = dir_fills + 32'd1;
            r.status     = STAT_FILLED;
          end
        end
      end
      default: begin
        // invalidations act even with the cache disabled
        for (int i = 0; i < SlotCount; i++) begin
          if (dir_valid[i] && (w.kind == KIND_INVAL_ALL || dir_tag[i] == w.file_tag)) begin
            dir_valid[i] = 1'b0;
            dir_invals   = dir_invals + 32'd1;
          end
        end
        r.status = STAT_INVALIDATED;
      end
    endcase
    r.hit_count          = dir_hits;
    r.miss_count         = dir_misses;
    r.fill_count         = dir_fills;
    r.invalidation_count = dir_invals;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------
  function automatic bcd_in_t make_word(kind_e k, logic [31:0] tag, logic [22:0] blk,
                                        logic [8:0] off, logic [LenW-1:0] req,
                                        logic [LenW-1:0] loaded);
    bcd_in_t w;
    w.kind            = k;
    w.file_tag        = tag;
    w.block_index     = blk;
    w.offset_in_block = off;
    w.request_length  = req;
    w.loaded_size     = loaded;
    return w;
  endfunction

  function automatic bcd_in_t rand_lookup(logic [31:0] tag, logic [22:0] blk);
    int unsigned p;
    logic [8:0]      off;
    logic [LenW-1:0] req;
    off = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 63));
    p   = $urandom_range(0, 99);
    if (p < 5)       req = '0;                              // zero length: bypass
    else if (p < 25) req = LenW'($urandom_range(513, 1023)); // past block end
    else             req = LenW'($urandom_range(1, 512));
    return make_word(KIND_LOOKUP, tag, blk, off, req, LenW'($urandom));
  endfunction

  function automatic bcd_in_t rand_fill(logic [31:0] tag, logic [22:0] blk);
    int unsigned p;
    logic [LenW-1:0] loaded;
    p = $urandom_range(0, 99);
    if (p < 10)      loaded = '0;                              // backend failure
    else if (p < 25) loaded = LenW'($urandom_range(513, 1023)); // saturates
    else if (p < 45) loaded = LenW'(BlockBytes);
    else             loaded = LenW'($urandom_range(1, 511));
    return make_word(KIND_FILL, tag, blk, 9'($urandom), LenW'($urandom), loaded);
  endfunction

  // ---------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------
  // Offers one word, returns at the edge it is accepted; valid stays high so
  // a back-to-back word can follow in the same step.
  task automatic send_word(bcd_in_t w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    reply_q.push_back(directory_update(w));
  endtask

  // Stops offering and waits until every predicted reply has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_cache_enable(logic en);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dir_enable  = en;
  endtask

  // ---------------------------------------------------------------------
  // Reply sink: random hold-off per word, or one long stall on request.
  // ---------------------------------------------------------------------
  initial begin : reply_sink
    int unsigned hold;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_stall_req != 0) begin
        hold           = long_stall_req;
        long_stall_req = 0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  // Reply checker: every accepted word against the oldest prediction.
  always @(posedge clk_i) begin : reply_check
    bcd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected reply word %0h", $realtime, out_data_o);
      end else begin
        want = reply_q.pop_front();
        compare_field("status", want.status, out_data_o.status);
        compare_field("slot_number", want.slot_number, out_data_o.slot_number);
        compare_field("served_length", want.served_length, out_data_o.served_length);
        compare_field("hit_count", want.hit_count, out_data_o.hit_count);
        compare_field("miss_count", want.miss_count, out_data_o.miss_count);
        compare_field("fill_count", want.fill_count, out_data_o.fill_count);
        compare_field("invalidation_count", want.invalidation_count,
                      out_data_o.invalidation_count);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Field extremes and each corner of lookup, fill and invalidation.
  task automatic test_directed_cases();
    send_word(make_word(KIND_LOOKUP, TagLow, '0, '0, 10'd10, '0));         // miss on empty
    send_word(make_word(KIND_LOOKUP, TagLow, '0, '0, '0, '0));             // zero length
    send_word(make_word(KIND_FILL, TagLow, '0, '0, '0, '0));               // backend miss
    send_word(make_word(KIND_FILL, TagLow, '0, '0, '0, 10'd1023));         // oversized fill
    send_word(make_word(KIND_LOOKUP, TagLow, '0, '0, 10'd512, '0));        // full block hit
    send_word(make_word(KIND_LOOKUP, TagLow, '0, 9'd511, 10'd1023, '0));   // past block end
    send_word(make_word(KIND_FILL, TagHigh, BlkHigh, 9'd511, 10'd1023, 10'd100));
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, 9'd100, 10'd1, '0)); // eof at edge
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, 9'd511, 10'd5, '0)); // eof past
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, 9'd50, 10'd1000, '0)); // clip to valid
    send_word(make_word(KIND_FILL, TagHigh, BlkHigh, '0, '0, 10'd300));     // refill in place
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, 9'd299, 10'd1, '0));
    send_word(make_word(KIND_FILL, TagHigh, 23'd1, '0, '0, '0));            // failed, new slot
    send_word(make_word(KIND_FILL, TagLow, 23'd1, '0, '0, 10'd1));
    send_word(make_word(KIND_LOOKUP, TagLow, 23'd1, '0, 10'd1023, '0));
    send_word(make_word(KIND_LOOKUP, TagLow, 23'd1, 9'h155, 10'h2AA, 10'h155));
    send_word(make_word(KIND_INVAL_ONE, TagHigh, '0, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, '0, 10'd1, '0));
    send_word(make_word(KIND_INVAL_ALL, TagLow, BlkHigh, 9'd511, 10'd1023, 10'd1023));
    send_word(make_word(KIND_LOOKUP, TagLow, '0, '0, 10'd1, '0));
    send_word(make_word(KIND_LOOKUP, TagHigh, BlkHigh, 9'd511, 10'd1023, 10'd1023));
    wait_idle();
  endtask

  // Disabled cache: lookups and fills bypass, invalidations still count.
  task automatic test_disabled_cache();
    send_word(make_word(KIND_FILL, 32'hA5A5_0001, 23'd5, '0, '0, 10'd200));
    send_word(make_word(KIND_FILL, 32'h5A5A_0002, 23'd6, '0, '0, 10'd300));
    set_cache_enable(1'b0);
    send_word(make_word(KIND_LOOKUP, 32'hA5A5_0001, 23'd5, '0, 10'd10, '0));
    send_word(make_word(KIND_FILL, 32'hA5A5_0001, 23'd9, '0, '0, 10'd50));
    send_word(make_word(KIND_INVAL_ONE, 32'hA5A5_0001, '0, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, 32'h5A5A_0002, 23'd6, '0, 10'd400, '0));
    set_cache_enable(1'b1);
    send_word(make_word(KIND_LOOKUP, 32'h5A5A_0002, 23'd6, '0, 10'd400, '0));
    send_word(make_word(KIND_LOOKUP, 32'hA5A5_0001, 23'd5, '0, 10'd10, '0));
    wait_idle();
  endtask

  // Fill every slot, refresh a couple, then watch the oldest go first and
  // an invalidated slot get reused ahead of the oldest.
  task automatic test_lru_replacement();
    send_word(make_word(KIND_INVAL_ALL, '0, '0, '0, '0, '0));
    for (int i = 0; i < SlotCount; i++)
      send_word(make_word(KIND_FILL, 32'h1234_0000 + i, 23'(i), '0, '0, 10'd64));
    send_word(make_word(KIND_LOOKUP, 32'h1234_0000, 23'd0, '0, 10'd8, '0));
    send_word(make_word(KIND_LOOKUP, 32'h1234_0001, 23'd1, '0, 10'd8, '0));
    send_word(make_word(KIND_FILL, 32'h1234_0100, 23'd100, '0, '0, 10'd64));
    send_word(make_word(KIND_FILL, 32'h1234_0101, 23'd101, '0, '0, 10'd64));
    send_word(make_word(KIND_LOOKUP, 32'h1234_0002, 23'd2, '0, 10'd8, '0));
    send_word(make_word(KIND_LOOKUP, 32'h1234_0000, 23'd0, '0, 10'd8, '0));
    send_word(make_word(KIND_INVAL_ONE, 32'h1234_0005, '0, '0, '0, '0));
    send_word(make_word(KIND_FILL, 32'h1234_0102, 23'd102, '0, '0, 10'd64));
    wait_idle();
  endtask

  // Mostly lookup-fill-lookup sequences on pooled keys, some stray lookups
  // and fills, noise words and invalidations. Four phases; the second runs
  // gap-free and the third with the cache disabled.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned count;
    int unsigned pick;
    int unsigned reps;
    logic [31:0] tag;
    logic [22:0] blk;
    for (int ph = 0; ph < 4; ph++) begin
      set_cache_enable(ph != 2);
      no_idle = (ph == 1);
      count   = (ph == 2) ? 100 : 300;
      sent    = 0;
      while (sent < count) begin
        pick = $urandom_range(0, 99);
        tag  = tag_pool[$urandom_range(0, 3)];
        blk  = blk_pool[$urandom_range(0, 5)];
        if (pick < 55) begin
          reps = $urandom_range(1, 3);
          send_word(rand_lookup(tag, blk));
          send_word(rand_fill(tag, blk));
          repeat (reps) send_word(rand_lookup(tag, blk));
          sent += 2 + reps;
        end else if (pick < 80) begin
          send_word(rand_lookup(tag, blk));
          sent++;
        end else if (pick < 88) begin
          send_word(rand_fill(tag, blk));
          sent++;
        end else if (pick < 94) begin
          send_word(make_word(kind_e'($urandom_range(0, 3)), $urandom, 23'($urandom),
                              9'($urandom), LenW'($urandom), LenW'($urandom)));
          sent++;
        end else if (pick < 99) begin
          send_word(make_word(KIND_INVAL_ONE, tag, 23'($urandom), 9'($urandom),
                              LenW'($urandom), LenW'($urandom)));
          sent++;
        end else begin
          send_word(make_word(KIND_INVAL_ALL, $urandom, 23'($urandom), 9'($urandom),
                              LenW'($urandom), LenW'($urandom)));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Receiver stalls for a long stretch while words keep coming gap-free, so
  // the block backs up and drops in_ready; then the sender drains fully.
  task automatic test_input_backpressure();
    no_idle        = 1'b1;
    long_stall_req = LongStall;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 1)
        send_word(rand_fill(tag_pool[i % 4], blk_pool[i % 6]));
      else
        send_word(rand_lookup(tag_pool[i % 4], blk_pool[i % 6]));
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 1'b0;
    in_valid_i     <= 1'b0;
    in_data_i      <= '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    long_stall_req = 0;
    reset_directory();
    tag_pool[0] = TagLow;
    tag_pool[1] = TagHigh;
    tag_pool[2] = $urandom;
    tag_pool[3] = $urandom;
    blk_pool[0] = '0;
    blk_pool[1] = BlkHigh;
    for (int i = 2; i < 6; i++) blk_pool[i] = 23'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_disabled_cache();
    test_lru_replacement();
    test_random_traffic();
    test_input_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("block_cache_directory_lru test passed");
    end else begin
      $display("block_cache_directory_lru test failed");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #1_000_000;
    $display("block_cache_directory_lru test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bcd_pkg.sv
design/bcd_slot_mem.sv
design/bcd_scan.sv
design/block_cache_directory_lru.sv
design/bcd_checker.sv
verif/tb_block_cache_directory_lru.sv
